// File: rtl/core/hcr_pkg.sv
// ----------------------------------------------------------------------------
// Harris corner response package
// Shared constants, types and helper functions of the corner response block.
// ----------------------------------------------------------------------------
package hcr_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int WINDOW_RADIUS = 2;
  localparam int DELAY         = WINDOW_RADIUS + 1;
  localparam int BOX_N         = 2 * WINDOW_RADIUS + 1;
  localparam int HIST_ROWS     = BOX_N - 1;
  localparam int MIN_SIZE      = 5;
  localparam int NUM_STAGES    = 10;

  localparam int PIX_W     = 8;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int OROW_W    = $clog2(MAX_HEIGHT);
  localparam int SIZE_W    = 11;
  localparam int ROW_W     = 11;
  localparam int THR_W     = 32;
  localparam int RESP_W    = 46;
  localparam int IDX_W     = 2;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 13;
  localparam int GRAD_W    = 11;
  localparam int SQ_W      = 2 * GRAD_W;
  localparam int PROD_W    = 16;
  localparam int COLSUM_W  = 19;
  localparam int BOXSUM_W  = 21;
  localparam int CALC_W    = 48;
  localparam int PROD_MAX  = 2 ** (PROD_W - 1) - 1;
  localparam int PROD_MIN  = -(2 ** (PROD_W - 1));

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
  localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(10000);

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_THRESHOLD    = 2'd2;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [SIZE_W-1:0] col;
  } pos_t;

  typedef struct packed {
    logic col_zero;
    logic col_one;
    logic top_edge;
    logic bot_edge;
  } sobel_ctl_t;

  typedef struct packed {
    logic              pos_valid;
    logic              in_area;
    logic [OROW_W-1:0] row;
    logic [COL_W-1:0]  col;
  } out_info_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] x2;
    logic signed [PROD_W-1:0] y2;
    logic signed [PROD_W-1:0] xy;
  } prod_t;

  typedef prod_t [HIST_ROWS-1:0] prod_hist_t;

  typedef struct packed {
    logic signed [COLSUM_W-1:0] x2;
    logic signed [COLSUM_W-1:0] y2;
    logic signed [COLSUM_W-1:0] xy;
  } col_sum_t;

  typedef struct packed {
    logic signed [BOXSUM_W-1:0] x2;
    logic signed [BOXSUM_W-1:0] y2;
    logic signed [BOXSUM_W-1:0] xy;
  } box_sum_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    if (v < SIZE_W'(MIN_SIZE)) return SIZE_W'(MIN_SIZE);
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pos_t normalize(input pos_t p, input logic [SIZE_W-1:0] w,
                                     input logic [SIZE_W-1:0] h);
    pos_t             q;
    logic [ROW_W:0]   lim;
    q = p;
    if (q.col >= w) begin
      q.col = '0;
      q.row = q.row + 1'b1;
    end
    lim = (ROW_W+1)'(h) + (ROW_W+1)'(DELAY);
    if ({1'b0, q.row} > lim || ({1'b0, q.row} == lim && q.col >= SIZE_W'(DELAY))) begin
      q = '0;
    end
    return q;
  endfunction

  function automatic logic signed [PROD_W-1:0] sat16(input logic signed [SQ_W-1:0] v);
    if (v > SQ_W'(PROD_MAX)) return PROD_W'(PROD_MAX);
    if (v < SQ_W'(PROD_MIN)) return PROD_W'(PROD_MIN);
    return PROD_W'(v);
  endfunction

endpackage

// File: rtl/core/hcr_pixel_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one gray pixel per transaction.
// ----------------------------------------------------------------------------
interface hcr_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [hcr_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

// File: rtl/core/hcr_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one corner response result per transaction.
// ----------------------------------------------------------------------------
interface hcr_result_if;
  logic                               valid;
  logic                               ready;
  logic                               position_valid;
  logic [hcr_pkg::OROW_W-1:0]         out_row;
  logic [hcr_pkg::COL_W-1:0]          out_col;
  logic                               in_area;
  logic                               is_corner;
  logic signed [hcr_pkg::RESP_W-1:0]  response_x25;

  modport source (output valid, output position_valid, output out_row, output out_col,
                  output in_area, output is_corner, output response_x25, input ready);
  modport sink (input valid, input position_valid, input out_row, input out_col,
                input in_area, input is_corner, input response_x25, output ready);
endinterface

// File: rtl/core/hcr_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface hcr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [hcr_pkg::IDX_W-1:0]    index;
  logic [hcr_pkg::DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/hcr_box_cell.sv
// ----------------------------------------------------------------------------
// Box filter cell
// Holds one column sum of the window, passes it to its neighbor on a shift
// and adds it to the running box sum that flows along the chain.
// ----------------------------------------------------------------------------
module hcr_box_cell (
  input  logic              clk,
  input  logic              shift,
  input  hcr_pkg::col_sum_t col_in,
  input  hcr_pkg::box_sum_t acc_in,
  output hcr_pkg::col_sum_t col_out,
  output hcr_pkg::box_sum_t acc_out
);

  always_ff @(posedge clk) begin
    if (shift) begin
      col_out <= col_in;
    end
  end

  always_comb begin
    acc_out.x2 = acc_in.x2 + hcr_pkg::BOXSUM_W'(col_out.x2);
    acc_out.y2 = acc_in.y2 + hcr_pkg::BOXSUM_W'(col_out.y2);
    acc_out.xy = acc_in.xy + hcr_pkg::BOXSUM_W'(col_out.xy);
  end

endmodule

// File: rtl/core/hcr_sobel.sv
// ----------------------------------------------------------------------------
// Sobel gradient stage
// Two-row pixel line store, 3x3 column window with border reflection and
// the horizontal and vertical Sobel gradients.
// ----------------------------------------------------------------------------
module hcr_sobel (
  input  logic                               clk,
  input  logic                               adv,
  input  logic                               accept,
  input  logic [hcr_pkg::PIX_W-1:0]          pixel,
  input  logic [hcr_pkg::COL_W-1:0]          col,
  input  hcr_pkg::sobel_ctl_t                ctl,
  input  logic                               valid_s1,
  output logic signed [hcr_pkg::GRAD_W-1:0]  gx,
  output logic signed [hcr_pkg::GRAD_W-1:0]  gy
);

  typedef struct packed {
    logic [hcr_pkg::PIX_W-1:0] top;
    logic [hcr_pkg::PIX_W-1:0] mid;
    logic [hcr_pkg::PIX_W-1:0] bot;
  } pix_col_t;

  logic [2*hcr_pkg::PIX_W-1:0] line_mem [hcr_pkg::MAX_WIDTH];
  logic [2*hcr_pkg::PIX_W-1:0] rd_word;
  logic [hcr_pkg::PIX_W-1:0]   pix_s1;
  logic [hcr_pkg::COL_W-1:0]   addr_s1;
  hcr_pkg::sobel_ctl_t         ctl_s1;
  pix_col_t                    win1;
  pix_col_t                    win2;
  pix_col_t                    new_col;
  pix_col_t                    left;
  pix_col_t                    mid;
  pix_col_t                    right;
  logic signed [hcr_pkg::GRAD_W-1:0] gx_next;
  logic signed [hcr_pkg::GRAD_W-1:0] gy_next;

  function automatic logic signed [hcr_pkg::GRAD_W-1:0] weigh3(
      input logic [hcr_pkg::PIX_W-1:0] a, input logic [hcr_pkg::PIX_W-1:0] b,
      input logic [hcr_pkg::PIX_W-1:0] c);
    return $signed(hcr_pkg::GRAD_W'(a) + hcr_pkg::GRAD_W'({b, 1'b0}) + hcr_pkg::GRAD_W'(c));
  endfunction

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= line_mem[col];
      pix_s1  <= pixel;
      addr_s1 <= col;
      ctl_s1  <= ctl;
    end
    if (adv && valid_s1) begin
      line_mem[addr_s1] <= {rd_word[hcr_pkg::PIX_W-1:0], pix_s1};
      win2              <= win1;
      win1              <= new_col;
    end
  end

  always_comb begin
    new_col.top = ctl_s1.top_edge ? pix_s1 : rd_word[2*hcr_pkg::PIX_W-1:hcr_pkg::PIX_W];
    new_col.mid = rd_word[hcr_pkg::PIX_W-1:0];
    new_col.bot = ctl_s1.bot_edge ? rd_word[2*hcr_pkg::PIX_W-1:hcr_pkg::PIX_W] : pix_s1;
    mid = win1;
    if (ctl_s1.col_zero) begin
      left  = win2;
      right = win2;
    end else if (ctl_s1.col_one) begin
      left  = new_col;
      right = new_col;
    end else begin
      left  = win2;
      right = new_col;
    end
    gx_next = weigh3(right.top, right.mid, right.bot) - weigh3(left.top, left.mid, left.bot);
    gy_next = weigh3(left.bot, mid.bot, right.bot) - weigh3(left.top, mid.top, right.top);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gx <= gx_next;
      gy <= gy_next;
    end
  end

endmodule

// File: rtl/core/hcr_box.sv
// ----------------------------------------------------------------------------
// Structure tensor box filter
// Saturated gradient products, vertical sums through a product line store
// and horizontal sums along a chain of column cells.
// ----------------------------------------------------------------------------
module hcr_box (
  input  logic                               clk,
  input  logic                               adv,
  input  logic                               valid_s2,
  input  logic                               valid_s3,
  input  logic [hcr_pkg::COL_W-1:0]          col_s2,
  input  logic signed [hcr_pkg::GRAD_W-1:0]  gx,
  input  logic signed [hcr_pkg::GRAD_W-1:0]  gy,
  output hcr_pkg::box_sum_t                  sums
);

  hcr_pkg::prod_hist_t             hist_mem [hcr_pkg::MAX_WIDTH];
  hcr_pkg::prod_hist_t             hist_rd;
  hcr_pkg::prod_hist_t             hist_wr;
  hcr_pkg::prod_t                  prod_s3;
  hcr_pkg::prod_t                  prod_next;
  logic [hcr_pkg::COL_W-1:0]       addr_s3;
  logic signed [hcr_pkg::SQ_W-1:0] sq_x;
  logic signed [hcr_pkg::SQ_W-1:0] sq_y;
  logic signed [hcr_pkg::SQ_W-1:0] sq_xy;
  hcr_pkg::col_sum_t               col_chain [0:hcr_pkg::BOX_N];
  hcr_pkg::box_sum_t               acc_chain [0:hcr_pkg::BOX_N];
  logic                            shift;

  always_comb begin
    sq_x  = gx * gx;
    sq_y  = gy * gy;
    sq_xy = gx * gy;
    prod_next.x2 = hcr_pkg::sat16(sq_x);
    prod_next.y2 = hcr_pkg::sat16(sq_y);
    prod_next.xy = hcr_pkg::sat16(sq_xy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_s3 <= prod_next;
      addr_s3 <= col_s2;
    end
    if (adv && valid_s2) begin
      hist_rd <= hist_mem[col_s2];
    end
    if (adv && valid_s3) begin
      hist_mem[addr_s3] <= hist_wr;
    end
  end

  always_comb begin
    col_chain[0].x2 = hcr_pkg::COLSUM_W'(prod_s3.x2);
    col_chain[0].y2 = hcr_pkg::COLSUM_W'(prod_s3.y2);
    col_chain[0].xy = hcr_pkg::COLSUM_W'(prod_s3.xy);
    for (int k = 0; k < hcr_pkg::HIST_ROWS; k++) begin
      col_chain[0].x2 = col_chain[0].x2 + hcr_pkg::COLSUM_W'(hist_rd[k].x2);
      col_chain[0].y2 = col_chain[0].y2 + hcr_pkg::COLSUM_W'(hist_rd[k].y2);
      col_chain[0].xy = col_chain[0].xy + hcr_pkg::COLSUM_W'(hist_rd[k].xy);
    end
    for (int k = 0; k < hcr_pkg::HIST_ROWS - 1; k++) begin
      hist_wr[k] = hist_rd[k+1];
    end
    hist_wr[hcr_pkg::HIST_ROWS-1] = prod_s3;
  end

  assign shift        = adv & valid_s3;
  assign acc_chain[0] = '0;

  for (genvar k = 0; k < hcr_pkg::BOX_N; k++) begin : g_cell
    hcr_box_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .col_in  (col_chain[k]),
      .acc_in  (acc_chain[k]),
      .col_out (col_chain[k+1]),
      .acc_out (acc_chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sums <= acc_chain[hcr_pkg::BOX_N];
    end
  end

endmodule

// File: rtl/core/harris_corner_response_top.sv
// ----------------------------------------------------------------------------
// Harris corner response
// Throughput: one pixel and one result per cycle; the pipeline stalls as a
// whole only while the result register is full and not taken.
// Reset clears the position counters and the pipeline valid bits and loads the
// configuration registers with their defaults; the line stores are not cleared.
// ----------------------------------------------------------------------------
module harris_corner_response_top (
  input  logic           clk,
  input  logic           rst,
  hcr_pixel_if.sink      pixels,
  hcr_result_if.source   results,
  hcr_cfg_if.sink        cfg
);

  logic [hcr_pkg::SIZE_W-1:0]      image_width;
  logic [hcr_pkg::SIZE_W-1:0]      image_height;
  logic [hcr_pkg::THR_W-1:0]       threshold;
  logic [hcr_pkg::ROW_W-1:0]       row_counter;
  logic [hcr_pkg::COL_W-1:0]       col_counter;
  logic [hcr_pkg::NUM_STAGES:1]    valid_pipe;
  hcr_pkg::out_info_t              info [1:hcr_pkg::NUM_STAGES-1];
  logic [hcr_pkg::COL_W-1:0]       cx1;
  logic [hcr_pkg::COL_W-1:0]       cx2;

  logic                            adv;
  logic                            accept;
  logic [hcr_pkg::SIZE_W-1:0]      w;
  logic [hcr_pkg::SIZE_W-1:0]      h;
  hcr_pkg::pos_t                   cur;
  hcr_pkg::pos_t                   step;
  hcr_pkg::pos_t                   nxt;
  logic signed [hcr_pkg::POS_W-1:0] r_s;
  logic signed [hcr_pkg::POS_W-1:0] c_s;
  logic signed [hcr_pkg::POS_W-1:0] w_s;
  logic signed [hcr_pkg::POS_W-1:0] h_s;
  logic signed [hcr_pkg::POS_W-1:0] orow_s;
  logic signed [hcr_pkg::POS_W-1:0] ocol_s;
  hcr_pkg::out_info_t              info_in;
  hcr_pkg::sobel_ctl_t             ctl;
  logic [hcr_pkg::SIZE_W-1:0]      wm1;
  logic [hcr_pkg::SIZE_W-1:0]      cm1;
  logic [hcr_pkg::COL_W-1:0]       cx_in;

  logic signed [hcr_pkg::GRAD_W-1:0] gx;
  logic signed [hcr_pkg::GRAD_W-1:0] gy;
  hcr_pkg::box_sum_t                 sums;

  logic signed [2*hcr_pkg::BOXSUM_W-1:0] a6;
  logic signed [2*hcr_pkg::BOXSUM_W-1:0] b6;
  logic signed [hcr_pkg::BOXSUM_W:0]     tr6;
  logic signed [2*hcr_pkg::BOXSUM_W:0]   det7;
  logic signed [2*hcr_pkg::BOXSUM_W+1:0] c7;
  logic signed [hcr_pkg::CALC_W-1:0]     det_w;
  logic signed [hcr_pkg::CALC_W-1:0]     m8;
  logic signed [hcr_pkg::CALC_W-1:0]     c8;
  logic signed [hcr_pkg::CALC_W-1:0]     resp9;
  logic signed [hcr_pkg::CALC_W-1:0]     thr_w;
  logic signed [hcr_pkg::CALC_W-1:0]     thr25;

  logic                                  res_pos_valid;
  logic [hcr_pkg::OROW_W-1:0]            res_row;
  logic [hcr_pkg::COL_W-1:0]             res_col;
  logic                                  res_in_area;
  logic                                  res_corner;
  logic signed [hcr_pkg::RESP_W-1:0]     res_resp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= hcr_pkg::WIDTH_RESET;
      image_height <= hcr_pkg::HEIGHT_RESET;
      threshold    <= hcr_pkg::THR_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        hcr_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data[hcr_pkg::SIZE_W-1:0];
        hcr_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data[hcr_pkg::SIZE_W-1:0];
        hcr_pkg::REG_THRESHOLD:    threshold    <= cfg.data[hcr_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv           = ~valid_pipe[hcr_pkg::NUM_STAGES] | results.ready;
  assign accept        = pixels.valid & adv;
  assign pixels.ready  = adv;

  always_comb begin
    w    = hcr_pkg::clamp_size(image_width, hcr_pkg::SIZE_W'(hcr_pkg::MAX_WIDTH));
    h    = hcr_pkg::clamp_size(image_height, hcr_pkg::SIZE_W'(hcr_pkg::MAX_HEIGHT));
    cur  = hcr_pkg::normalize('{row: row_counter, col: hcr_pkg::SIZE_W'(col_counter)}, w, h);
    step = cur;
    step.col = cur.col + 1'b1;
    nxt  = hcr_pkg::normalize(step, w, h);

    r_s = $signed(hcr_pkg::POS_W'(cur.row));
    c_s = $signed(hcr_pkg::POS_W'(cur.col));
    w_s = $signed(hcr_pkg::POS_W'(w));
    h_s = $signed(hcr_pkg::POS_W'(h));
    if (cur.col >= hcr_pkg::SIZE_W'(hcr_pkg::DELAY)) begin
      orow_s = r_s - hcr_pkg::POS_W'(hcr_pkg::DELAY);
      ocol_s = c_s - hcr_pkg::POS_W'(hcr_pkg::DELAY);
    end else begin
      orow_s = r_s - hcr_pkg::POS_W'(hcr_pkg::DELAY + 1);
      ocol_s = c_s + w_s - hcr_pkg::POS_W'(hcr_pkg::DELAY);
    end
    info_in.pos_valid = (orow_s >= 0) && (orow_s < h_s) && (ocol_s >= 0) && (ocol_s < w_s);
    info_in.in_area   = info_in.pos_valid
                        && (orow_s >= hcr_pkg::POS_W'(hcr_pkg::WINDOW_RADIUS))
                        && (orow_s <= h_s - hcr_pkg::POS_W'(hcr_pkg::WINDOW_RADIUS + 1))
                        && (ocol_s >= hcr_pkg::POS_W'(hcr_pkg::WINDOW_RADIUS))
                        && (ocol_s <= w_s - hcr_pkg::POS_W'(hcr_pkg::WINDOW_RADIUS + 1));
    info_in.row = orow_s[hcr_pkg::OROW_W-1:0];
    info_in.col = ocol_s[hcr_pkg::COL_W-1:0];

    ctl.col_zero = (cur.col == '0);
    ctl.col_one  = (cur.col == hcr_pkg::SIZE_W'(1));
    ctl.top_edge = (cur.row == hcr_pkg::ROW_W'(1));
    ctl.bot_edge = (cur.row == h);
    wm1   = w - 1'b1;
    cm1   = cur.col - 1'b1;
    cx_in = ctl.col_zero ? wm1[hcr_pkg::COL_W-1:0] : cm1[hcr_pkg::COL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      col_counter <= '0;
      valid_pipe  <= '0;
    end else begin
      if (accept) begin
        row_counter <= nxt.row;
        col_counter <= nxt.col[hcr_pkg::COL_W-1:0];
      end
      if (adv) begin
        valid_pipe <= {valid_pipe[hcr_pkg::NUM_STAGES-1:1], accept};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      info[1] <= info_in;
      for (int k = 2; k < hcr_pkg::NUM_STAGES; k++) begin
        info[k] <= info[k-1];
      end
      cx1 <= cx_in;
      cx2 <= cx1;
    end
  end

  hcr_sobel u_sobel (
    .clk      (clk),
    .adv      (adv),
    .accept   (accept),
    .pixel    (pixels.pixel),
    .col      (cur.col[hcr_pkg::COL_W-1:0]),
    .ctl      (ctl),
    .valid_s1 (valid_pipe[1]),
    .gx       (gx),
    .gy       (gy)
  );

  hcr_box u_box (
    .clk      (clk),
    .adv      (adv),
    .valid_s2 (valid_pipe[2]),
    .valid_s3 (valid_pipe[3]),
    .col_s2   (cx2),
    .gx       (gx),
    .gy       (gy),
    .sums     (sums)
  );

  // The response is scaled by 25 so that the 0.04 trace weight stays integer.
  assign det_w = hcr_pkg::CALC_W'(det7);
  assign thr_w = $signed(hcr_pkg::CALC_W'(threshold));

  always_ff @(posedge clk) begin
    thr25 <= (thr_w <<< 4) + (thr_w <<< 3) + thr_w;
    if (adv) begin
      a6    <= sums.x2 * sums.y2;
      b6    <= sums.xy * sums.xy;
      tr6   <= (hcr_pkg::BOXSUM_W+1)'(sums.x2) + (hcr_pkg::BOXSUM_W+1)'(sums.y2);
      det7  <= (2*hcr_pkg::BOXSUM_W+1)'(a6) - (2*hcr_pkg::BOXSUM_W+1)'(b6);
      c7    <= tr6 * tr6;
      m8    <= (det_w <<< 4) + (det_w <<< 3) + det_w;
      c8    <= hcr_pkg::CALC_W'(c7);
      resp9 <= m8 - c8;

      res_pos_valid <= info[hcr_pkg::NUM_STAGES-1].pos_valid;
      res_row       <= info[hcr_pkg::NUM_STAGES-1].pos_valid ?
                       info[hcr_pkg::NUM_STAGES-1].row : '0;
      res_col       <= info[hcr_pkg::NUM_STAGES-1].pos_valid ?
                       info[hcr_pkg::NUM_STAGES-1].col : '0;
      res_in_area   <= info[hcr_pkg::NUM_STAGES-1].in_area;
      res_corner    <= info[hcr_pkg::NUM_STAGES-1].in_area && (resp9 > thr25);
      res_resp      <= info[hcr_pkg::NUM_STAGES-1].in_area ?
                       resp9[hcr_pkg::RESP_W-1:0] : '0;
    end
  end

  assign results.valid          = valid_pipe[hcr_pkg::NUM_STAGES];
  assign results.position_valid = res_pos_valid;
  assign results.out_row        = res_row;
  assign results.out_col        = res_col;
  assign results.in_area        = res_in_area;
  assign results.is_corner      = res_corner;
  assign results.response_x25   = res_resp;

endmodule
